>>> hdl/annealing_accept_and_cooling_macros.svh
// assertion macros for the annealing acceptance block
// no dependencies
`ifndef ANNEALING_ACCEPT_AND_COOLING_MACROS_SVH
`define ANNEALING_ACCEPT_AND_COOLING_MACROS_SVH
`ifndef ASSERT_OFF
`define AAC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AAC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define AAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/aac_pkg.sv
// types and constants for the annealing acceptance block
// no dependencies
package aac_pkg;
    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_DIV, S_SQ_A, S_SQ_B, S_DEC, S_COOL_A, S_COOL_B,
        S_HEAT_A, S_HEAT_B, S_FIN, S_OUT
    } t_state;
    localparam int FACTOR_BITS = 17;
    localparam int ROUND_BITS  = 16;
    localparam int COUNT_BITS  = 17;
    localparam int SQUARINGS   = 16;
    localparam int DRAW_BITS   = 16;
    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_MIN    = 3'd1;
    localparam logic [2:0] REG_BOUNCE = 3'd2;
    localparam logic [2:0] REG_COOL   = 3'd3;
    localparam logic [2:0] REG_HEAT   = 3'd4;
    localparam logic [2:0] REG_ROUNDS = 3'd5;
    localparam logic [2:0] REG_REJ    = 3'd6;
endpackage

>>> hdl/annealing_accept_and_cooling.sv
// annealing acceptance test and temperature schedule, top level; uses aac_pkg and macros file
// when the exponential is needed the result follows 47 restoring divide steps and 16 squarings
// on one shared 32x32 multiplier; both are skipped when the candidate is taken outright or
// the exponent is out of range
// one item at a time; i_stall holds the result
// synchronous active-low reset loads start_temperature and clears the counters
`include "annealing_accept_and_cooling_macros.svh"
module annealing_accept_and_cooling #(
    parameter int COST_BITS      = 10,
    parameter int TEMP_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [COST_BITS-1:0]          i_current_cost,
    input  logic [COST_BITS-1:0]          i_candidate_cost,
    input  logic [aac_pkg::DRAW_BITS-1:0] i_uniform_draw,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic [COST_BITS-1:0]          o_kept_cost,
    output logic [TEMP_FRAC_BITS+7:0]     o_temperature_now,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int TB = 8 + TEMP_FRAC_BITS;
    localparam int MB = COST_BITS + 5;
    localparam int NB = MB + TEMP_FRAC_BITS + 16;
    localparam int CB = aac_pkg::COUNT_BITS;
    localparam int PB = TB + aac_pkg::FACTOR_BITS;
    localparam logic [TB-1:0] TMAX = {TB{1'b1}};
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};
    localparam logic [TB-1:0] ONE  = TB'(1) << TEMP_FRAC_BITS;
    localparam logic [TB-1:0] START_RST  = TB'(50) << TEMP_FRAC_BITS;
    localparam logic [TB-1:0] BOUNCE_RST = TB'(2) << TEMP_FRAC_BITS;

    aac_pkg::t_state r_state, n_state;
    logic [TB-1:0] r_start, r_min, r_bounce, r_temp, n_temp;
    logic [aac_pkg::FACTOR_BITS-1:0] r_cool, r_heat;
    logic [aac_pkg::ROUND_BITS-1:0] r_rounds, r_rej_lim;
    logic [CB-1:0] r_round, n_round, r_rej, n_rej;
    logic [COST_BITS-1:0] r_cur, r_cand;
    logic [aac_pkg::DRAW_BITS-1:0] r_draw;
    logic [MB-1:0] r_m;
    logic [NB-1:0] r_num;
    logic [TB:0] r_rem;
    logic [NB-1:0] r_quo;
    logic [$clog2(NB+1)-1:0] r_bit;
    logic [32:0] r_z;
    logic [63:0] r_prod;
    logic [4:0] r_sq;
    logic r_acc, n_acc;
    logic r_ovalid;
    logic [TB-1:0] w_r;
    logic w_wr;
    logic [TB:0] w_trial;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mul;
    logic [PB-1:0] w_tp;
    logic [TB-1:0] w_sat;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_r = (r_temp == '0) ? TB'(1) : r_temp;
    assign w_trial = {r_rem[TB-1:0], r_num[NB-1]};
    // shared multiplier: squarings, then cooling and reheat scalings
    assign w_ma = (r_state inside {aac_pkg::S_COOL_A, aac_pkg::S_HEAT_A}) ?
                  32'(r_temp) : r_z[31:0];
    assign w_mb = (r_state == aac_pkg::S_COOL_A) ? 32'(r_cool) :
                  (r_state == aac_pkg::S_HEAT_A) ? 32'(r_heat) : r_z[31:0];
    assign w_mul = 64'(w_ma) * 64'(w_mb);
    assign w_tp = PB'(r_prod) >> 16;
    assign w_sat = (w_tp > PB'(TMAX)) ? TMAX : w_tp[TB-1:0];

    always_comb begin
        case (paddr[4:2])
            aac_pkg::REG_START:  prdata = 32'(r_start);
            aac_pkg::REG_MIN:    prdata = 32'(r_min);
            aac_pkg::REG_BOUNCE: prdata = 32'(r_bounce);
            aac_pkg::REG_COOL:   prdata = 32'(r_cool);
            aac_pkg::REG_HEAT:   prdata = 32'(r_heat);
            aac_pkg::REG_ROUNDS: prdata = 32'(r_rounds);
            aac_pkg::REG_REJ:    prdata = 32'(r_rej_lim);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aac_pkg::S_IDLE:   if (i_valid) n_state = aac_pkg::S_CHK;
            aac_pkg::S_CHK: begin
                if (r_cand <= r_cur) n_state = aac_pkg::S_DEC;
                else if (((NB+4)'(r_m) << (TEMP_FRAC_BITS-4)) >= (NB+4)'(w_r))
                    n_state = aac_pkg::S_DEC;
                else n_state = aac_pkg::S_DIV;
            end
            aac_pkg::S_DIV:    if (r_bit == '0) n_state = aac_pkg::S_SQ_A;
            aac_pkg::S_SQ_A:   n_state = aac_pkg::S_SQ_B;
            aac_pkg::S_SQ_B:   n_state = (r_sq == 5'(aac_pkg::SQUARINGS-1)) ?
                                         aac_pkg::S_DEC : aac_pkg::S_SQ_A;
            aac_pkg::S_DEC:    n_state = aac_pkg::S_COOL_A;
            aac_pkg::S_COOL_A: n_state = aac_pkg::S_COOL_B;
            aac_pkg::S_COOL_B: n_state = aac_pkg::S_HEAT_A;
            aac_pkg::S_HEAT_A: n_state = aac_pkg::S_HEAT_B;
            aac_pkg::S_HEAT_B: n_state = aac_pkg::S_FIN;
            aac_pkg::S_FIN:    n_state = aac_pkg::S_OUT;
            aac_pkg::S_OUT:    if (!i_stall) n_state = aac_pkg::S_IDLE;
            default:           n_state = aac_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != aac_pkg::S_IDLE);
        o_valid = r_ovalid;
        o_accepted = r_acc;
        o_kept_cost = r_acc ? r_cand : r_cur;
        o_temperature_now = r_temp;
    end

    // schedule updates
    always_comb begin
        n_acc = r_acc;
        n_rej = r_rej;
        n_round = r_round;
        n_temp = r_temp;
        case (r_state)
            aac_pkg::S_DEC: begin
                if (r_cand <= r_cur) n_acc = 1'b1;
                else n_acc = r_quo != '0 && r_z[31:0] > {r_draw, 16'd0};
                if (n_acc) n_rej = '0;
                else if (r_rej < CMAX) n_rej = r_rej + 1'b1;
                if (r_round < CMAX) n_round = r_round + 1'b1;
            end
            aac_pkg::S_COOL_B:
                if (r_round > CB'(r_rounds) && r_temp > r_min) begin
                    n_round = '0;
                    n_temp = w_sat;
                end
            aac_pkg::S_HEAT_B:
                if (r_rej > CB'(r_rej_lim)) begin
                    if (r_temp < r_bounce) n_temp = w_sat;
                    n_rej = '0;
                end
            aac_pkg::S_FIN: if (r_temp == '0) n_temp = ONE;
            default: ;
        endcase
        if (w_wr && paddr[4:2] == aac_pkg::REG_START) n_temp = pwdata[TB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aac_pkg::S_IDLE;
            r_start <= START_RST;
            r_min <= ONE;
            r_bounce <= BOUNCE_RST;
            r_cool <= 17'd64881;
            r_heat <= 17'd72090;
            r_rounds <= 16'd1000;
            r_rej_lim <= 16'd2000;
            r_temp <= START_RST;
            r_round <= '0;
            r_rej <= '0;
            r_ovalid <= 1'b0;
            r_acc <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc <= n_acc;
            r_rej <= n_rej;
            r_round <= n_round;
            r_temp <= n_temp;
            r_ovalid <= (n_state == aac_pkg::S_OUT);
            if (w_wr) begin
                case (paddr[4:2])
                    aac_pkg::REG_START:  r_start <= pwdata[TB-1:0];
                    aac_pkg::REG_MIN:    r_min <= pwdata[TB-1:0];
                    aac_pkg::REG_BOUNCE: r_bounce <= pwdata[TB-1:0];
                    aac_pkg::REG_COOL:   r_cool <= pwdata[16:0];
                    aac_pkg::REG_HEAT:   r_heat <= pwdata[16:0];
                    aac_pkg::REG_ROUNDS: r_rounds <= pwdata[15:0];
                    aac_pkg::REG_REJ:    r_rej_lim <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            aac_pkg::S_IDLE: if (i_valid) begin
                r_cur <= i_current_cost;
                r_cand <= i_candidate_cost;
                r_draw <= i_uniform_draw;
                r_m <= MB'(i_candidate_cost - i_current_cost) * MB'(20) - MB'(2);
                r_quo <= '0;
                r_z <= '0;
            end
            aac_pkg::S_CHK: begin
                r_num <= NB'(r_m) << (TEMP_FRAC_BITS + 16);
                r_rem <= '0;
                r_bit <= ($clog2(NB+1))'(NB - 1);
                r_sq <= '0;
            end
            aac_pkg::S_DIV: begin
                r_num <= r_num << 1;
                if (w_trial >= {1'b0, w_r}) begin
                    r_rem <= w_trial - {1'b0, w_r};
                    r_quo <= {r_quo[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[NB-2:0], 1'b0};
                end
                if (r_bit == '0)
                    r_z <= 33'h1_0000_0000 - 33'({r_quo[NB-2:0],
                           w_trial >= {1'b0, w_r}});
                else r_bit <= r_bit - 1'b1;
            end
            aac_pkg::S_SQ_A: r_prod <= (r_z[32]) ? 64'hFFFF_FFFF_FFFF_FFFF : w_mul;
            aac_pkg::S_SQ_B: begin
                r_z <= r_z[32] ? 33'h1_0000_0000 : {1'b0, r_prod[63:32]};
                r_sq <= r_sq + 1'b1;
            end
            aac_pkg::S_COOL_A, aac_pkg::S_HEAT_A: r_prod <= w_mul;
            default: ;
        endcase
    end

    `AAC_ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, !o_valid || o_stall, "result while idle")
    `AAC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kept_cost), "result dropped")
    `AAC_ASSERT_IMPL(a_temp_nz, i_clk, i_rst_n, !o_valid || o_temperature_now != '0, "zero temperature out")
endmodule

>>> test/tb.sv
// testbench for annealing_accept_and_cooling: random and directed cost/draw transfers,
// a scoreboard class predicting acceptance and the temperature schedule, apb setup phases
// depends on aac_pkg and the block's rtl
`timescale 1ns / 1ps
module tb;

    class anneal_scoreboard;
        longint unsigned start_t, min_t, bounce_t, alpha, beta, cool_rounds, heat_rejects;
        longint unsigned temp, rounds, rejects;
        bit [0:0]  acc_q[$];
        bit [9:0]  kept_q[$];
        bit [23:0] temp_q[$];
        int errors;

        function new();
            start_t = 3276800; min_t = 65536; bounce_t = 131072;
            alpha = 64881; beta = 72090; cool_rounds = 1000; heat_rejects = 2000;
            temp = start_t; rounds = 0; rejects = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, longint unsigned v);
            case (idx)
                aac_pkg::REG_START: begin
                    start_t = v & 24'hFFFFFF;
                    temp = start_t;
                end
                aac_pkg::REG_MIN:    min_t = v & 24'hFFFFFF;
                aac_pkg::REG_BOUNCE: bounce_t = v & 24'hFFFFFF;
                aac_pkg::REG_COOL:   alpha = v & 17'h1FFFF;
                aac_pkg::REG_HEAT:   beta = v & 17'h1FFFF;
                aac_pkg::REG_ROUNDS: cool_rounds = v & 16'hFFFF;
                aac_pkg::REG_REJ:    heat_rejects = v & 16'hFFFF;
                default: ;
            endcase
        endfunction

        function longint unsigned scale(longint unsigned t, longint unsigned f);
            longint unsigned p;
            p = (t * f) >> 16;
            return (p > 24'hFFFFFF) ? 24'hFFFFFF : p;
        endfunction

        function void note_input(longint unsigned cur, longint unsigned cand,
                                 longint unsigned draw);
            longint unsigned m, r, z;
            bit acc;
            if (cand <= cur) begin
                acc = 1;
            end else begin
                m = 20 * (cand - cur) - 2;
                r = (temp == 0) ? 1 : temp;
                if ((m << 12) >= r) begin
                    z = 0;
                end else begin
                    z = (64'd1 << 32) - ((m << 32) / r);
                    for (int i = 0; i < aac_pkg::SQUARINGS; i++) z = (z * z) >> 32;
                end
                acc = z > (draw << 16);
            end
            if (acc) rejects = 0;
            else if (rejects < 131071) rejects++;
            if (rounds < 131071) rounds++;
            if (rounds > cool_rounds && temp > min_t) begin
                rounds = 0;
                temp = scale(temp, alpha);
            end
            if (rejects > heat_rejects) begin
                if (temp < bounce_t) temp = scale(temp, beta);
                rejects = 0;
            end
            if (temp == 0) temp = 64'd1 << 16;
            acc_q.push_back(acc);
            kept_q.push_back(acc ? cand[9:0] : cur[9:0]);
            temp_q.push_back(temp[23:0]);
        endfunction

        function void check_result(bit acc, bit [9:0] kept, bit [23:0] t);
            bit [0:0] ea;
            bit [9:0] ek;
            bit [23:0] et;
            if (acc_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
                return;
            end
            ea = acc_q.pop_front();
            ek = kept_q.pop_front();
            et = temp_q.pop_front();
            if (ea != acc || ek != kept || et != t) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp acc=%0d kept=%0d temp=%h %s%0d kept=%0d temp=%h",
                             ea, ek, et, "got acc=", acc, kept, t);
            end
        endfunction

        function int pending();
            return acc_q.size();
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, i_stall;
    logic        o_stall, o_valid, o_accepted;
    logic [9:0]  i_current_cost, i_candidate_cost, o_kept_cost;
    logic [15:0] i_uniform_draw;
    logic [23:0] o_temperature_now;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    anneal_scoreboard sb = new();
    bit quiet = 0;
    bit hold_req = 0;

    annealing_accept_and_cooling u_top (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_input(64'(i_current_cost), 64'(i_candidate_cost), 64'(i_uniform_draw));
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_accepted, o_kept_cost, o_temperature_now);
    end

    // receiver side
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_req = 0;
                @(posedge i_clk);
            end else if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(3) == 0) begin
                n = $urandom_range(12, 1);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                n = $urandom_range(20, 1);
                i_stall <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, 64'(v));
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [9:0] cur, logic [9:0] cand, logic [15:0] draw);
        int n;
        if (!quiet && $urandom_range(3) == 0) begin
            n = $urandom_range(12, 1);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_current_cost <= cur; i_candidate_cost <= cand; i_uniform_draw <= draw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        logic [9:0] cur, cand;
        int d;
        for (int k = 0; k < count; k++) begin
            cur = 10'($urandom_range(1023));
            if ($urandom_range(9) < 3) begin
                cand = 10'($urandom_range(1023));
            end else begin
                d = $urandom_range(6);
                cand = (cur + d > 1023) ? 10'd1023 : 10'(cur + d);
                if ($urandom_range(4) == 0) cand = 10'(cur - d);
            end
            send_item(cur, cand, 16'($urandom_range(65535)));
        end
    endtask

    task automatic write_all(logic [31:0] st, logic [31:0] mn, logic [31:0] bl,
                             logic [31:0] a, logic [31:0] b, logic [31:0] cr, logic [31:0] rr);
        apb_write(aac_pkg::REG_MIN, mn);
        apb_write(aac_pkg::REG_BOUNCE, bl);
        apb_write(aac_pkg::REG_COOL, a);
        apb_write(aac_pkg::REG_HEAT, b);
        apb_write(aac_pkg::REG_ROUNDS, cr);
        apb_write(aac_pkg::REG_REJ, rr);
        apb_write(aac_pkg::REG_START, st);
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_current_cost = '0; i_candidate_cost = '0; i_uniform_draw = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed at reset settings
        send_item(10'd5, 10'd5, 16'hFFFF);
        send_item(10'd1023, 10'd0, 16'hFFFF);
        send_item(10'd0, 10'd1023, 16'h0000);
        send_item(10'd0, 10'd1023, 16'hFFFF);
        send_item(10'd100, 10'd101, 16'h0000);
        send_item(10'd100, 10'd101, 16'hFFFF);
        send_item(10'd100, 10'd101, 16'h8000);
        send_item(10'd1022, 10'd1023, 16'h5555);
        send_item(10'd1, 10'd3, 16'hAAAA);
        send_item(10'd512, 10'd520, 16'h0001);
        send_item(10'd0, 10'd0, 16'h0000);
        send_item(10'd341, 10'd682, 16'h1234);
        drain();

        // zero start temperature, then tight schedule with hold-off
        apb_write(aac_pkg::REG_START, 32'd0);
        send_item(10'd10, 10'd11, 16'h0000);
        send_item(10'd10, 10'd12, 16'h0000);
        drain();
        write_all(32'd131072, 32'd0, 32'hFFFFFF, 32'd131071, 32'd131071, 32'd3, 32'd2);
        hold_req = 1;
        send_random(250);
        drain();

        // smallest factors and counts
        write_all(32'hFFFFFF, 32'd0, 32'hFFFFFF, 32'd1, 32'd1, 32'd1, 32'd1);
        send_random(200);
        drain();

        // largest counts, full range registers, stray address
        write_all(32'd65536, 32'hFFFFFF, 32'd0, 32'd65535, 32'd70000, 32'd65535, 32'd65535);
        apb_write(3'd7, 32'hFFFFFFFF);
        send_random(200);
        drain();

        // moderate schedule
        write_all(32'd655360, 32'd32768, 32'd1310720, 32'd60000, 32'd90000, 32'd20, 32'd8);
        send_random(300);
        drain();

        // last part without idling
        quiet = 1;
        write_all(32'd3276800, 32'd65536, 32'd131072, 32'd64881, 32'd72090, 32'd7, 32'd5);
        send_random(330);
        drain();

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
